// ===== hdl/ilat_pkg.sv =====
// Shared types, constants, operation table and saturation helpers of the lever-arm unit.
`default_nettype none

package ilat_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int COEF_BITS   = 18;
    localparam int WIDE_BITS   = 48;
    localparam int STAMP_BITS  = 63;
    localparam int ROW_BITS    = 3 * COEF_BITS;
    localparam int DT_BITS     = 30;
    localparam int OPND_BITS   = WIDE_BITS + 1;
    localparam int MAG_A_BITS  = WIDE_BITS;
    localparam int MAG_B_BITS  = SAMPLE_BITS;
    localparam int PROD_BITS   = MAG_A_BITS + MAG_B_BITS;
    localparam int NUM_BITS    = 62;
    localparam int ACC_BITS    = WIDE_BITS + 3;
    localparam int N_OPS       = 39;
    localparam int OP_BITS     = 6;
    localparam int IN_BITS     = 256;
    localparam int OUT_BITS    = 6 * SAMPLE_BITS;
    localparam int CFG_BITS    = 64;
    localparam int ADDR_BITS   = 6;

    localparam logic [DT_BITS-1:0]    DT_RESET = DT_BITS'(5000000);
    localparam logic [OPND_BITS-1:0]  NS_PER_S = OPND_BITS'(1000000000);
    localparam logic [WIDE_BITS-1:0]  LIM_NEG  = {1'b1, {(WIDE_BITS-1){1'b0}}};
    localparam logic [WIDE_BITS-1:0]  LIM_POS  = {1'b0, {(WIDE_BITS-1){1'b1}}};
    localparam logic [OP_BITS-1:0]    LAST_OP  = OP_BITS'(N_OPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        REG_ROT0,
        REG_ROT1,
        REG_ROT2,
        REG_LEVER,
        REG_DT
    } cfg_t;

    typedef enum logic [2:0] {
        A_GYRO,
        A_ACCEL,
        A_DW,
        A_ALPHA,
        A_W,
        A_NEGU
    } a_src_t;

    typedef enum logic [1:0] {
        B_COEF,
        B_NS,
        B_NEGT,
        B_W
    } b_src_t;

    typedef enum logic [2:0] {
        D_W,
        D_RA,
        D_ALPHA,
        D_T1,
        D_U,
        D_T2
    } dst_t;

    typedef enum logic [1:0] {
        SH0,
        SH12,
        SH16
    } shift_t;

    typedef struct packed {
        a_src_t      a_src;
        logic [1:0]  a_idx;
        b_src_t      b_src;
        logic [1:0]  b_idx;
        dst_t        dst;
        logic [1:0]  d_idx;
        shift_t      sh;
        logic        sub;
        logic        first;
        logic        last;
    } op_t;

    function automatic op_t mk_op(input a_src_t as, input logic [1:0] ai,
                                  input b_src_t bs, input logic [1:0] bi,
                                  input dst_t ds, input logic [1:0] di,
                                  input shift_t sh, input logic sb,
                                  input logic fi, input logic la);
        op_t o;
        o.a_src = as;
        o.a_idx = ai;
        o.b_src = bs;
        o.b_idx = bi;
        o.dst   = ds;
        o.d_idx = di;
        o.sh    = sh;
        o.sub   = sb;
        o.first = fi;
        o.last  = la;
        return o;
    endfunction

    // Operation sequence: rotations, alpha numerators, then the three cross products
    function automatic op_t op_rom(input logic [OP_BITS-1:0] idx);
        op_t o;
        case (idx)
            6'd0:  o = mk_op(A_GYRO, 2'd0, B_COEF, 2'd0, D_W, 2'd0, SH16, 1'b0, 1'b1, 1'b0);
            6'd1:  o = mk_op(A_GYRO, 2'd1, B_COEF, 2'd1, D_W, 2'd0, SH16, 1'b0, 1'b0, 1'b0);
            6'd2:  o = mk_op(A_GYRO, 2'd2, B_COEF, 2'd2, D_W, 2'd0, SH16, 1'b0, 1'b0, 1'b1);
            6'd3:  o = mk_op(A_GYRO, 2'd0, B_COEF, 2'd0, D_W, 2'd1, SH16, 1'b0, 1'b1, 1'b0);
            6'd4:  o = mk_op(A_GYRO, 2'd1, B_COEF, 2'd1, D_W, 2'd1, SH16, 1'b0, 1'b0, 1'b0);
            6'd5:  o = mk_op(A_GYRO, 2'd2, B_COEF, 2'd2, D_W, 2'd1, SH16, 1'b0, 1'b0, 1'b1);
            6'd6:  o = mk_op(A_GYRO, 2'd0, B_COEF, 2'd0, D_W, 2'd2, SH16, 1'b0, 1'b1, 1'b0);
            6'd7:  o = mk_op(A_GYRO, 2'd1, B_COEF, 2'd1, D_W, 2'd2, SH16, 1'b0, 1'b0, 1'b0);
            6'd8:  o = mk_op(A_GYRO, 2'd2, B_COEF, 2'd2, D_W, 2'd2, SH16, 1'b0, 1'b0, 1'b1);
            6'd9:  o = mk_op(A_ACCEL, 2'd0, B_COEF, 2'd0, D_RA, 2'd0, SH16, 1'b0, 1'b1, 1'b0);
            6'd10: o = mk_op(A_ACCEL, 2'd1, B_COEF, 2'd1, D_RA, 2'd0, SH16, 1'b0, 1'b0, 1'b0);
            6'd11: o = mk_op(A_ACCEL, 2'd2, B_COEF, 2'd2, D_RA, 2'd0, SH16, 1'b0, 1'b0, 1'b1);
            6'd12: o = mk_op(A_ACCEL, 2'd0, B_COEF, 2'd0, D_RA, 2'd1, SH16, 1'b0, 1'b1, 1'b0);
            6'd13: o = mk_op(A_ACCEL, 2'd1, B_COEF, 2'd1, D_RA, 2'd1, SH16, 1'b0, 1'b0, 1'b0);
            6'd14: o = mk_op(A_ACCEL, 2'd2, B_COEF, 2'd2, D_RA, 2'd1, SH16, 1'b0, 1'b0, 1'b1);
            6'd15: o = mk_op(A_ACCEL, 2'd0, B_COEF, 2'd0, D_RA, 2'd2, SH16, 1'b0, 1'b1, 1'b0);
            6'd16: o = mk_op(A_ACCEL, 2'd1, B_COEF, 2'd1, D_RA, 2'd2, SH16, 1'b0, 1'b0, 1'b0);
            6'd17: o = mk_op(A_ACCEL, 2'd2, B_COEF, 2'd2, D_RA, 2'd2, SH16, 1'b0, 1'b0, 1'b1);
            6'd18: o = mk_op(A_DW, 2'd0, B_NS, 2'd0, D_ALPHA, 2'd0, SH0, 1'b0, 1'b1, 1'b1);
            6'd19: o = mk_op(A_DW, 2'd1, B_NS, 2'd0, D_ALPHA, 2'd1, SH0, 1'b0, 1'b1, 1'b1);
            6'd20: o = mk_op(A_DW, 2'd2, B_NS, 2'd0, D_ALPHA, 2'd2, SH0, 1'b0, 1'b1, 1'b1);
            6'd21: o = mk_op(A_ALPHA, 2'd1, B_NEGT, 2'd2, D_T1, 2'd0, SH12, 1'b0, 1'b1, 1'b0);
            6'd22: o = mk_op(A_ALPHA, 2'd2, B_NEGT, 2'd1, D_T1, 2'd0, SH12, 1'b1, 1'b0, 1'b1);
            6'd23: o = mk_op(A_ALPHA, 2'd2, B_NEGT, 2'd0, D_T1, 2'd1, SH12, 1'b0, 1'b1, 1'b0);
            6'd24: o = mk_op(A_ALPHA, 2'd0, B_NEGT, 2'd2, D_T1, 2'd1, SH12, 1'b1, 1'b0, 1'b1);
            6'd25: o = mk_op(A_ALPHA, 2'd0, B_NEGT, 2'd1, D_T1, 2'd2, SH12, 1'b0, 1'b1, 1'b0);
            6'd26: o = mk_op(A_ALPHA, 2'd1, B_NEGT, 2'd0, D_T1, 2'd2, SH12, 1'b1, 1'b0, 1'b1);
            6'd27: o = mk_op(A_W, 2'd1, B_NEGT, 2'd2, D_U, 2'd0, SH12, 1'b0, 1'b1, 1'b0);
            6'd28: o = mk_op(A_W, 2'd2, B_NEGT, 2'd1, D_U, 2'd0, SH12, 1'b1, 1'b0, 1'b1);
            6'd29: o = mk_op(A_W, 2'd2, B_NEGT, 2'd0, D_U, 2'd1, SH12, 1'b0, 1'b1, 1'b0);
            6'd30: o = mk_op(A_W, 2'd0, B_NEGT, 2'd2, D_U, 2'd1, SH12, 1'b1, 1'b0, 1'b1);
            6'd31: o = mk_op(A_W, 2'd0, B_NEGT, 2'd1, D_U, 2'd2, SH12, 1'b0, 1'b1, 1'b0);
            6'd32: o = mk_op(A_W, 2'd1, B_NEGT, 2'd0, D_U, 2'd2, SH12, 1'b1, 1'b0, 1'b1);
            6'd33: o = mk_op(A_NEGU, 2'd2, B_W, 2'd1, D_T2, 2'd0, SH16, 1'b0, 1'b1, 1'b0);
            6'd34: o = mk_op(A_NEGU, 2'd1, B_W, 2'd2, D_T2, 2'd0, SH16, 1'b1, 1'b0, 1'b1);
            6'd35: o = mk_op(A_NEGU, 2'd0, B_W, 2'd2, D_T2, 2'd1, SH16, 1'b0, 1'b1, 1'b0);
            6'd36: o = mk_op(A_NEGU, 2'd2, B_W, 2'd0, D_T2, 2'd1, SH16, 1'b1, 1'b0, 1'b1);
            6'd37: o = mk_op(A_NEGU, 2'd1, B_W, 2'd0, D_T2, 2'd2, SH16, 1'b0, 1'b1, 1'b0);
            6'd38: o = mk_op(A_NEGU, 2'd0, B_W, 2'd1, D_T2, 2'd2, SH16, 1'b1, 1'b0, 1'b1);
            default: o = mk_op(A_GYRO, 2'd0, B_COEF, 2'd0, D_W, 2'd0, SH0, 1'b0, 1'b1, 1'b1);
        endcase
        return o;
    endfunction

    // Clamp an accumulator value to the wide intermediate range
    function automatic logic signed [WIDE_BITS-1:0] sat_wide(input logic signed [ACC_BITS-1:0] x);
        logic signed [WIDE_BITS-1:0] r;
        if ((&x[ACC_BITS-1:WIDE_BITS-1]) || !(|x[ACC_BITS-1:WIDE_BITS-1]))
            r = x[WIDE_BITS-1:0];
        else if (x[ACC_BITS-1])
            r = LIM_NEG;
        else
            r = LIM_POS;
        return r;
    endfunction

    // Clamp an accumulator value to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] x);
        logic signed [SAMPLE_BITS-1:0] r;
        if ((&x[ACC_BITS-1:SAMPLE_BITS-1]) || !(|x[ACC_BITS-1:SAMPLE_BITS-1]))
            r = x[SAMPLE_BITS-1:0];
        else if (x[ACC_BITS-1])
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ilat_mul.sv =====
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module ilat_mul (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [ilat_pkg::MAG_A_BITS-1:0]   a_mag,
    input  wire logic [ilat_pkg::MAG_B_BITS-1:0]   b_mag,
    output logic      [ilat_pkg::PROD_BITS-1:0]    product,
    output logic                                   done
);
    import ilat_pkg::*;

    localparam int CNT_BITS = $clog2(MAG_B_BITS);

    logic [MAG_A_BITS-1:0] a_reg;
    logic [PROD_BITS-1:0]  p_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [MAG_A_BITS:0]   sum;

    // Add the multiplicand into the upper half when the current bit is set
    assign sum = {1'b0, p_reg[PROD_BITS-1:MAG_B_BITS]}
               + (p_reg[0] ? {1'b0, a_reg} : {(MAG_A_BITS+1){1'b0}});

    // Hold control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MAG_B_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the partial product right one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a_mag;
            p_reg <= {{MAG_A_BITS{1'b0}}, b_mag};
        end
        else if (busy_reg)
        begin
            p_reg <= {sum, p_reg[MAG_B_BITS-1:1]};
        end
    end

    assign product = p_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

// ===== hdl/ilat_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module ilat_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [ilat_pkg::NUM_BITS-1:0]      num,
    input  wire logic [ilat_pkg::STAMP_BITS-1:0]    den,
    output logic      [ilat_pkg::NUM_BITS-1:0]      quot,
    output logic                                    done
);
    import ilat_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS);

    logic [STAMP_BITS-1:0] r_reg;
    logic [STAMP_BITS-1:0] den_reg;
    logic [NUM_BITS-1:0]   n_reg;
    logic [NUM_BITS-1:0]   q_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [STAMP_BITS:0]   r2;
    logic [STAMP_BITS:0]   rd;
    logic                  ge;

    // Bring down the next numerator bit and try the subtraction
    assign r2 = {r_reg, n_reg[NUM_BITS-1]};
    assign rd = r2 - {1'b0, den_reg};
    assign ge = (r2 >= {1'b0, den_reg});

    // Hold control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(NUM_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= '0;
            n_reg   <= num;
            q_reg   <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? rd[STAMP_BITS-1:0] : r2[STAMP_BITS-1:0];
            n_reg <= {n_reg[NUM_BITS-2:0], 1'b0};
            q_reg <= {q_reg[NUM_BITS-2:0], ge};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hdl/imu_lever_arm_transform_unit.sv =====
// Top level: IMU extrinsic rotation with lever-arm compensation.
// Usage:
//   Slave stream s_axis takes one IMU sample per request (timestamp, gyro,
//   accelerometer). Master stream m_axis returns the rotated gyro and the
//   compensated acceleration, one result per sample.
//   The APB port holds the three rotation rows, the lever arm and the
//   default interval; write it only while the block is idle.
// Sequencing:
//   Work runs through one bit-serial multiplier and a bit-serial divider,
//   set by a microcoded sequencer. Each of the 39 products passes through
//   a load state and the multiplier run up to its done strobe; each of the
//   three divisions adds a divider run up to its done strobe. A sample
//   also passes an interval preparation state and a result hand-over
//   state; the divider is skipped when the interval is zero. One sample
//   is in work at a time; s_axis_tready is high only while the sequencer
//   is idle, so a new sample is accepted only after the last one has been
//   handed to the output register.
// Stalls:
//   The result sits in an output register; the next sample is accepted
//   while it waits. A finished sample holds in the last state until the
//   output register is free.
// Reset:
//   rst_n clears the sequencer, the output valid, the history (first sample
//   pending, last timestamp and gyro zero) and the registers to defaults.
`default_nettype none

module imu_lever_arm_transform_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // stamp_ns[62:0], gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, pad
    input  wire logic [ilat_pkg::IN_BITS-1:0]     s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // body_gyro_x[31:0], body_gyro_y, body_gyro_z, body_accel_x, _y, _z
    output logic      [ilat_pkg::OUT_BITS-1:0]    m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ilat_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [ilat_pkg::CFG_BITS-1:0]    pwdata,
    output logic      [ilat_pkg::CFG_BITS-1:0]    prdata,
    output logic                                  pready
);
    import ilat_pkg::*;

    // configuration
    logic [ROW_BITS-1:0] rot_reg [3];
    logic [ROW_BITS-1:0] lever_reg;
    logic [DT_BITS-1:0]  dt_reg;

    // control and history
    state_t                       state_reg, state_next;
    logic [OP_BITS-1:0]           op_idx_reg, op_idx_next;
    logic                         out_valid_reg;
    logic                         first_reg;
    logic [STAMP_BITS-1:0]        last_stamp_reg;
    logic signed [SAMPLE_BITS-1:0] last_gyro_reg [3];

    // sample and working registers
    logic [STAMP_BITS-1:0]         stamp_reg;
    logic [STAMP_BITS:0]           diff_reg;
    logic [STAMP_BITS-1:0]         den_reg;
    logic                          den_neg_reg;
    logic                          den_zero_reg;
    logic signed [SAMPLE_BITS-1:0] g_reg [3];
    logic signed [SAMPLE_BITS-1:0] acl_reg [3];
    logic signed [SAMPLE_BITS-1:0] w_reg [3];
    logic signed [WIDE_BITS-1:0]   ra_reg [3];
    logic signed [WIDE_BITS-1:0]   al_reg [3];
    logic signed [WIDE_BITS-1:0]   t1_reg [3];
    logic signed [WIDE_BITS-1:0]   u_reg [3];
    logic signed [WIDE_BITS-1:0]   t2_reg [3];
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic                          neg_reg;
    logic [OUT_BITS-1:0]           out_data_reg;

    // sequencer strobes
    logic in_accept;
    logic cfg_write;
    logic mul_start;
    logic div_start;
    logic advance;
    logic fin_load;

    // datapath
    op_t                          op;
    logic signed [OPND_BITS-1:0]  a_val;
    logic signed [OPND_BITS-1:0]  b_val;
    logic [OPND_BITS-1:0]         a_abs;
    logic [OPND_BITS-1:0]         b_abs;
    logic [PROD_BITS-1:0]         product;
    logic                         mul_done;
    logic [NUM_BITS-1:0]          quot;
    logic                         div_done;
    logic [PROD_BITS-1:0]         shifted;
    logic [WIDE_BITS-1:0]         mag_clamp;
    logic signed [ACC_BITS-1:0]   m_val;
    logic signed [ACC_BITS-1:0]   acc_sum;
    logic                         al_neg;
    logic [WIDE_BITS-1:0]         q_clamp;
    logic signed [WIDE_BITS-1:0]  alpha;
    logic [STAMP_BITS:0]          diff_neg;
    logic [STAMP_BITS-1:0]        den_raw;
    logic [STAMP_BITS-1:0]        den_sel;
    logic signed [SAMPLE_BITS-1:0] res_acc [3];
    logic signed [SAMPLE_BITS:0]  dw;
    logic [COEF_BITS-1:0]         coef;
    logic [COEF_BITS-1:0]         lev;

    assign op        = op_rom(op_idx_reg);
    assign in_accept = s_axis_tvalid && (state_reg == ST_IDLE);
    assign cfg_write = psel && penable && pwrite;

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_idx_reg <= op_idx_next;
        end
    end

    // Sequencer next state and strobes
    always_comb
    begin
        state_next  = state_reg;
        op_idx_next = op_idx_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        advance     = 1'b0;
        fin_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                op_idx_next = '0;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (op.dst == D_ALPHA && !den_zero_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        advance = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    advance = 1'b1;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    fin_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (advance)
        begin
            if (op_idx_reg == LAST_OP)
                state_next = ST_FIN;
            else
            begin
                op_idx_next = op_idx_reg + 1'b1;
                state_next  = ST_LOAD;
            end
        end
    end

    // Select operand A
    always_comb
    begin
        dw = {w_reg[op.a_idx][SAMPLE_BITS-1], w_reg[op.a_idx]}
           - {last_gyro_reg[op.a_idx][SAMPLE_BITS-1], last_gyro_reg[op.a_idx]};
        case (op.a_src)
            A_GYRO:  a_val = OPND_BITS'(g_reg[op.a_idx]);
            A_ACCEL: a_val = OPND_BITS'(acl_reg[op.a_idx]);
            A_DW:    a_val = first_reg ? '0 : OPND_BITS'(dw);
            A_ALPHA: a_val = OPND_BITS'(al_reg[op.a_idx]);
            A_W:     a_val = OPND_BITS'(w_reg[op.a_idx]);
            A_NEGU:  a_val = -OPND_BITS'(u_reg[op.a_idx]);
            default: a_val = '0;
        endcase
    end

    // Select operand B
    always_comb
    begin
        coef = rot_reg[op.d_idx][op.b_idx * COEF_BITS +: COEF_BITS];
        lev  = lever_reg[op.b_idx * COEF_BITS +: COEF_BITS];
        case (op.b_src)
            B_COEF:  b_val = OPND_BITS'($signed(coef));
            B_NS:    b_val = NS_PER_S;
            B_NEGT:  b_val = -OPND_BITS'($signed(lev));
            B_W:     b_val = OPND_BITS'(w_reg[op.b_idx]);
            default: b_val = '0;
        endcase
    end

    assign a_abs = a_val[OPND_BITS-1] ? -a_val : a_val;
    assign b_abs = b_val[OPND_BITS-1] ? -b_val : b_val;

    ilat_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a_mag   (a_abs[MAG_A_BITS-1:0]),
        .b_mag   (b_abs[MAG_B_BITS-1:0]),
        .product (product),
        .done    (mul_done)
    );

    ilat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (product[NUM_BITS-1:0]),
        .den   (den_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // Scale, clamp and sign the product, then accumulate
    always_comb
    begin
        case (op.sh)
            SH12:    shifted = product >> 12;
            SH16:    shifted = product >> 16;
            default: shifted = product;
        endcase
        if (neg_reg)
        begin
            if ((|shifted[PROD_BITS-1:WIDE_BITS])
                || (shifted[WIDE_BITS-1] && (|shifted[WIDE_BITS-2:0])))
                mag_clamp = LIM_NEG;
            else
                mag_clamp = shifted[WIDE_BITS-1:0];
            m_val = -$signed({3'b000, mag_clamp});
        end
        else
        begin
            if (|shifted[PROD_BITS-1:WIDE_BITS-1])
                mag_clamp = LIM_POS;
            else
                mag_clamp = shifted[WIDE_BITS-1:0];
            m_val = $signed({3'b000, mag_clamp});
        end
        if (op.first)
            acc_sum = m_val;
        else if (op.sub)
            acc_sum = acc_reg - m_val;
        else
            acc_sum = acc_reg + m_val;
    end

    // Clamp the quotient to the wide range with the sign of dw over dt
    always_comb
    begin
        al_neg = neg_reg ^ den_neg_reg;
        if (al_neg)
        begin
            if ((|quot[NUM_BITS-1:WIDE_BITS])
                || (quot[WIDE_BITS-1] && (|quot[WIDE_BITS-2:0])))
                q_clamp = LIM_NEG;
            else
                q_clamp = quot[WIDE_BITS-1:0];
            alpha = -$signed(q_clamp);
        end
        else
        begin
            if (|quot[NUM_BITS-1:WIDE_BITS-1])
                q_clamp = LIM_POS;
            else
                q_clamp = quot[WIDE_BITS-1:0];
            alpha = $signed(q_clamp);
        end
    end

    // Interval magnitude, sign and default substitution
    always_comb
    begin
        diff_neg = -diff_reg;
        if (first_reg)
            den_raw = '0;
        else if (diff_reg[STAMP_BITS])
            den_raw = diff_neg[STAMP_BITS-1:0];
        else
            den_raw = diff_reg[STAMP_BITS-1:0];
        den_sel = (den_raw == '0) ? STAMP_BITS'(dt_reg) : den_raw;
    end

    // Final sums of rotated acceleration and both lever-arm terms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res_acc[i] = sat_sample(ACC_BITS'(ra_reg[i]) + ACC_BITS'(t1_reg[i])
                                    + ACC_BITS'(t2_reg[i]));
        end
    end

    // Capture the sample and run the working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stamp_reg  <= s_axis_tdata[STAMP_BITS-1:0];
            diff_reg   <= {1'b0, s_axis_tdata[STAMP_BITS-1:0]} - {1'b0, last_stamp_reg};
            g_reg[0]   <= s_axis_tdata[STAMP_BITS + 0*SAMPLE_BITS +: SAMPLE_BITS];
            g_reg[1]   <= s_axis_tdata[STAMP_BITS + 1*SAMPLE_BITS +: SAMPLE_BITS];
            g_reg[2]   <= s_axis_tdata[STAMP_BITS + 2*SAMPLE_BITS +: SAMPLE_BITS];
            acl_reg[0] <= s_axis_tdata[STAMP_BITS + 3*SAMPLE_BITS +: SAMPLE_BITS];
            acl_reg[1] <= s_axis_tdata[STAMP_BITS + 4*SAMPLE_BITS +: SAMPLE_BITS];
            acl_reg[2] <= s_axis_tdata[STAMP_BITS + 5*SAMPLE_BITS +: SAMPLE_BITS];
        end
        if (state_reg == ST_PREP)
        begin
            den_reg      <= den_sel;
            den_neg_reg  <= !first_reg && diff_reg[STAMP_BITS];
            den_zero_reg <= (den_sel == '0);
        end
        if (mul_start)
            neg_reg <= a_val[OPND_BITS-1] ^ b_val[OPND_BITS-1];
        if (state_reg == ST_MUL && mul_done)
        begin
            if (op.dst == D_ALPHA)
            begin
                if (den_zero_reg)
                    al_reg[op.d_idx] <= '0;
            end
            else
            begin
                acc_reg <= acc_sum;
                if (op.last)
                begin
                    case (op.dst)
                        D_W:     w_reg[op.d_idx]  <= sat_sample(acc_sum);
                        D_RA:    ra_reg[op.d_idx] <= sat_wide(acc_sum);
                        D_T1:    t1_reg[op.d_idx] <= sat_wide(acc_sum);
                        D_U:     u_reg[op.d_idx]  <= sat_wide(acc_sum);
                        D_T2:    t2_reg[op.d_idx] <= sat_wide(acc_sum);
                        default: ;
                    endcase
                end
            end
        end
        if (state_reg == ST_DIV && div_done)
            al_reg[op.d_idx] <= alpha;
        if (fin_load)
        begin
            out_data_reg <= {res_acc[2], res_acc[1], res_acc[0],
                             w_reg[2], w_reg[1], w_reg[0]};
        end
    end

    // Hold history and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            first_reg      <= 1'b1;
            last_stamp_reg <= '0;
            for (int i = 0; i < 3; i++)
                last_gyro_reg[i] <= '0;
        end
        else
        begin
            if (fin_load)
            begin
                out_valid_reg  <= 1'b1;
                first_reg      <= 1'b0;
                last_stamp_reg <= stamp_reg;
                for (int i = 0; i < 3; i++)
                    last_gyro_reg[i] <= w_reg[i];
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                rot_reg[i] <= '0;
            lever_reg <= '0;
            dt_reg    <= DT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_t'(paddr[ADDR_BITS-1:3]))
                REG_ROT0:  rot_reg[0] <= pwdata[ROW_BITS-1:0];
                REG_ROT1:  rot_reg[1] <= pwdata[ROW_BITS-1:0];
                REG_ROT2:  rot_reg[2] <= pwdata[ROW_BITS-1:0];
                REG_LEVER: lever_reg  <= pwdata[ROW_BITS-1:0];
                REG_DT:    dt_reg     <= pwdata[DT_BITS-1:0];
                default:   dt_reg     <= dt_reg;
            endcase
        end
    end

    // Read configuration registers
    always_comb
    begin
        case (cfg_t'(paddr[ADDR_BITS-1:3]))
            REG_ROT0:  prdata = CFG_BITS'(rot_reg[0]);
            REG_ROT1:  prdata = CFG_BITS'(rot_reg[1]);
            REG_ROT2:  prdata = CFG_BITS'(rot_reg[2]);
            REG_LEVER: prdata = CFG_BITS'(lever_reg);
            REG_DT:    prdata = CFG_BITS'(dt_reg);
            default:   prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/ilat_checker.sv =====
// Port-level checks of the lever-arm unit, bound to the top level.
`default_nettype none

module ilat_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic pready
);

    // One sample in work: the input closes right after a request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after a request");

    // A result is never produced in the cycle after a request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared straight after a request");

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // The register port never inserts wait states
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind imu_lever_arm_transform_unit ilat_checker u_ilat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .pready        (pready)
);

`default_nettype wire
